>>> rtl/fir_pkg.sv
// Shared types and constants for the fixed-point FIR filter.
`timescale 1ns / 1ps

package fir_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 8;
	localparam int MAX_TAPS   = 32;
	localparam int IDX_W      = 5;
	localparam int PROD_W     = 2 * DATA_WIDTH;

	// Input word operation codes.
	localparam logic OP_FILTER = 1'b0;
	localparam logic OP_COEF   = 1'b1;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic [IDX_W-1:0]             idx_t;

	// Control from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic valid;
		logic clear;
	} mac_ctl_t;

endpackage

>>> rtl/fir_mac.sv
// Shared multiply-accumulate unit: registered product, then scaled accumulate.
`timescale 1ns / 1ps

module fir_mac (
	input  logic           clk,
	input  logic           arst_n,
	input  fir_pkg::mac_ctl_t ctl,
	input  fir_pkg::data_t coef,
	input  fir_pkg::data_t tap,
	output fir_pkg::data_t acc
);
	import fir_pkg::*;

	prod_t prod_s1;
	logic  valid_s1;
	logic  clear_s1;
	data_t acc_q;
	data_t term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			clear_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.valid;
			clear_s1 <= ctl.clear;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.valid) begin
			prod_s1 <= PROD_W'(coef) * PROD_W'(tap);
		end
	end

	// The arithmetic shift right by the fraction width keeps these bits.
	assign term = prod_s1[FRAC_BITS+DATA_WIDTH-1:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (valid_s1) begin
			acc_q <= (clear_s1 ? data_t'(0) : acc_q) + term;
		end
	end

	assign acc = acc_q;

endmodule

>>> rtl/fir_filter_fixed_point_top.sv
// Top level of the direct-form fixed-point FIR filter with a shared MAC.
`timescale 1ns / 1ps

// Channel | Handshake            | Payload
// --------+----------------------+------------------------------------------
// input   | in_valid / in_stall  | operation, sample_in, coef_index, coef_value
// output  | out_valid / out_stall| filtered_out
// config  | cfg_wr_en            | cfg_wr_data (filter order)
//
// A filter word sweeps taps zero to M, where M is the filter order, before
// the block is ready again. The single multiplier of the MAC unit handles
// one tap per cycle; the drain state then empties its product register, and
// the done state loads the output register. Reset clears the delay line, the
// coefficients and all control state at once, and sets the order to 31.
// The input stall is high while a sample is in work; a finished result waits
// in the output register, and the next word is taken meanwhile. If that
// register is still held when the next result is ready, the sequencer waits
// and the input stays stalled until the receiver takes the older word.

module fir_filter_fixed_point_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [4:0]               cfg_wr_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     operation,
	input  fir_pkg::data_t           sample_in,
	input  fir_pkg::idx_t            coef_index,
	input  fir_pkg::data_t           coef_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output fir_pkg::data_t           filtered_out
);
	import fir_pkg::*;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	idx_t       cnt_q;
	idx_t       order_q;
	idx_t       order_eff;
	data_t      sample_q;
	data_t      carry_q;
	data_t      delay_q [MAX_TAPS];
	data_t      coef_q  [MAX_TAPS];
	data_t      out_q;
	logic       out_valid_q;

	logic       in_take;
	logic       out_take;
	logic       out_load;
	logic       coef_wr_ok;
	data_t      tap_sel;
	data_t      coef_sel;
	data_t      acc;
	mac_ctl_t   mac_ctl;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// Orders past the last tap are clamped to it.
	assign order_eff = ((IDX_W+1)'(order_q) > (IDX_W+1)'(MAX_TAPS - 1))
		? IDX_W'(MAX_TAPS - 1) : order_q;

	assign coef_wr_ok = (IDX_W+1)'(coef_index) < (IDX_W+1)'(MAX_TAPS);

	// Tap zero uses the new sample; higher taps still hold their old values
	// because the sweep rewrites them only after reading.
	assign tap_sel  = (cnt_q == '0) ? sample_q : delay_q[cnt_q];
	assign coef_sel = coef_q[cnt_q];

	assign mac_ctl.valid = (state_q == ST_RUN);
	assign mac_ctl.clear = (cnt_q == '0);

	fir_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (coef_sel),
		.tap    (tap_sel),
		.acc    (acc)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= IDX_W'(31);
		end else if (cfg_wr_en) begin
			order_q <= cfg_wr_data;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_take && operation == OP_FILTER) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cnt_q == order_eff) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && operation == OP_FILTER) begin
			sample_q <= sample_in;
		end
		if (state_q == ST_RUN) begin
			carry_q <= tap_sel;
		end
	end

	// Delay line: tap zero takes the new sample, and during the sweep each
	// higher tap takes the value that the tap below it was read with, carried
	// over from the previous cycle, so tap one also receives the new sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				delay_q[i] <= '0;
			end
		end else if (state_q == ST_RUN) begin
			delay_q[cnt_q] <= (cnt_q == '0) ? sample_q : carry_q;
		end
	end

	// Coefficient store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (in_take && operation == OP_COEF && coef_wr_ok) begin
			coef_q[coef_index] <= coef_value;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= acc;
		end
	end

	assign out_valid    = out_valid_q;
	assign filtered_out = out_q;

endmodule
